FILE: sv/biw_pkg.sv
// Package of shared types and constants for the bitstream integer writer.
`timescale 1ns / 1ps
`default_nettype none

package biw_pkg;

   // Field codes carried in the opcode of a request transaction.
   localparam logic [2:0] OP_RAW     = 3'd0;
   localparam logic [2:0] OP_UVARINT = 3'd1;
   localparam logic [2:0] OP_SVARINT = 3'd2;
   localparam logic [2:0] OP_WORD32  = 3'd3;
   localparam logic [2:0] OP_UNBITS  = 3'd4;
   localparam logic [2:0] OP_SNBITS  = 3'd5;
   localparam logic [2:0] OP_FLUSH   = 3'd6;

   // Widest field one transaction can append: four varint chunks and a stop bit.
   localparam int FIELD_W = 37;
   // Bits held by the packer: up to seven leftover bits plus the widest field.
   localparam int WORK_W  = FIELD_W + 7;
   // Bit count width for fields and the packer fill level.
   localparam int LEN_W   = 6;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] value;
      logic [5:0]  bit_count;
   } biw_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } biw_rsp_type;

   // Classified field, left aligned: bit FIELD_W-1 goes out first.
   typedef struct packed {
      logic [FIELD_W-1:0] field;
      logic [LEN_W-1:0]   len;
      logic               flush;
   } biw_entry_type;

endpackage

`default_nettype wire

FILE: sv/biw_front.sv
// Front end: accepts request transactions and turns each into a left-aligned bit field.
`timescale 1ns / 1ps
`default_nettype none

module biw_front import biw_pkg::*; (
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire biw_req_type   req_payload,
   input  wire logic          queue_full,
   output logic               push_valid,
   output biw_entry_type      push_entry
);

   // Places the low m bits of x at the top of a 32-bit word.
   function automatic logic [31:0] align_top(input logic [31:0] x, input logic [5:0] m);
      logic [63:0] tmp;
      begin
         tmp = {32'd0, x} << (6'd32 - m);
         return tmp[31:0];
      end
   endfunction

   // Top m bits set, for saturated fields.
   function automatic logic [31:0] ones_top(input logic [5:0] m);
      begin
         return ~(32'hFFFF_FFFF >> m);
      end
   endfunction

   logic [5:0]  nbits;
   logic [5:0]  mbits;
   logic [31:0] v;
   logic [7:0]  b0, b1, b2, b3;
   logic [2:0]  uv_chunks;
   logic [2:0]  sv_chunks;
   logic [2:0]  chunks;
   logic [FIELD_W-1:0] varint_field;
   logic [LEN_W-1:0]   varint_len;
   logic [63:0] u_rest;
   logic        u_sat;
   logic [31:0] mag;
   logic        s_sat;
   logic [31:0] s_mag_al;
   logic [31:0] field32;

   assign v  = req_payload.value;
   assign b0 = v[7:0];
   assign b1 = v[15:8];
   assign b2 = v[23:16];
   assign b3 = v[31:24];

   // Width operand clamps at 32; the signed form spends one bit on the sign.
   assign nbits = (req_payload.bit_count > 6'd32) ? 6'd32 : req_payload.bit_count;
   assign mbits = (nbits == 6'd0) ? 6'd0 : nbits - 6'd1;

   // Unsigned varint sends every byte up to the highest nonzero one.
   always_comb begin
      if (b3 != 8'd0)            uv_chunks = 3'd4;
      else if (v[23:8] != 16'd0) uv_chunks = (b2 != 8'd0) ? 3'd3 : 3'd2;
      else if (b0 != 8'd0)      uv_chunks = 3'd1;
      else                       uv_chunks = 3'd0;
   end

   // Signed varint stops at the first byte count that holds the value as signed.
   always_comb begin
      if (v == 32'd0)                                      sv_chunks = 3'd0;
      else if (v[31:7] == '0 || v[31:7] == '1)             sv_chunks = 3'd1;
      else if (v[31:15] == '0 || v[31:15] == '1)           sv_chunks = 3'd2;
      else if (v[31:23] == '0 || v[31:23] == '1)           sv_chunks = 3'd3;
      else                                                 sv_chunks = 3'd4;
   end

   assign chunks = (req_payload.opcode == OP_SVARINT) ? sv_chunks : uv_chunks;

   // Chunk layout: a one flag and the byte per chunk, then a closing zero bit.
   always_comb begin
      case (chunks)
         3'd1: begin
            varint_field = {1'b1, b0, 1'b0, 27'd0};
            varint_len   = 6'd10;
         end
         3'd2: begin
            varint_field = {1'b1, b0, 1'b1, b1, 1'b0, 18'd0};
            varint_len   = 6'd19;
         end
         3'd3: begin
            varint_field = {1'b1, b0, 1'b1, b1, 1'b1, b2, 1'b0, 9'd0};
            varint_len   = 6'd28;
         end
         3'd4: begin
            varint_field = {1'b1, b0, 1'b1, b1, 1'b1, b2, 1'b1, b3, 1'b0};
            varint_len   = 6'd37;
         end
         default: begin
            varint_field = '0;
            varint_len   = 6'd1;
         end
      endcase
   end

   // Saturation checks for the fixed-width unsigned and signed forms.
   assign u_rest   = {32'd0, v} >> nbits;
   assign u_sat    = (u_rest != 64'd0);
   assign mag      = v[31] ? (32'd0 - v) : v;
   assign s_sat    = ((mag >> mbits) != 32'd0);
   assign s_mag_al = s_sat ? ones_top(mbits) : align_top(mag, mbits);

   // Select the field for the opcode.
   always_comb begin
      push_entry = '0;
      field32    = '0;
      push_valid = req_valid && !queue_full;
      case (req_payload.opcode)
         OP_RAW: begin
            field32          = align_top(v, nbits);
            push_entry.field = {field32, 5'd0};
            push_entry.len   = nbits;
         end
         OP_UVARINT, OP_SVARINT: begin
            push_entry.field = varint_field;
            push_entry.len   = varint_len;
         end
         OP_WORD32: begin
            push_entry.field = {b0, b1, b2, b3, 5'd0};
            push_entry.len   = 6'd32;
         end
         OP_UNBITS: begin
            field32          = u_sat ? ones_top(nbits) : align_top(v, nbits);
            push_entry.field = {field32, 5'd0};
            push_entry.len   = nbits;
         end
         OP_SNBITS: begin
            if (nbits != 6'd0) begin
               field32 = {v[31], s_mag_al[31:1]};
            end
            push_entry.field = {field32, 5'd0};
            push_entry.len   = nbits;
         end
         OP_FLUSH: begin
            push_entry.flush = 1'b1;
         end
         default: begin
            // Unused code: the transaction is taken and dropped.
            push_valid = 1'b0;
         end
      endcase
   end

   assign req_stall = queue_full;

endmodule

`default_nettype wire

FILE: sv/biw_queue.sv
// Two-entry queue of classified fields between the front end and the packer.
`timescale 1ns / 1ps
`default_nettype none

module biw_queue import biw_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   input  wire biw_entry_type push_entry,
   output logic               full,
   input  wire logic          pop,
   output logic               pop_valid,
   output biw_entry_type      pop_entry
);

   biw_entry_type entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

FILE: sv/biw_back.sv
// Packer: appends queued fields to the bit stream and sends out completed bytes.
`timescale 1ns / 1ps
`default_nettype none

module biw_back import biw_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          entry_valid,
   input  wire biw_entry_type entry,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output biw_rsp_type        rsp_payload
);

   // Pending stream bits, first bit at the top; bits below the count are zero.
   logic [WORK_W-1:0] work_ff, work_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   biw_rsp_type       rsp_payload_ff, rsp_payload_in;

   logic [2:0]        held;
   logic [LEN_W-1:0]  len_eff;
   logic [WORK_W-1:0] merged;
   logic [WORK_W-1:0] src;
   logic [LEN_W-1:0]  src_count;
   logic              out_free;
   logic              emit;

   assign held     = count_ff[2:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Take the next field once fewer than eight bits remain.
   assign pop = entry_valid && (count_ff < 6'd8);

   // A flush pads the held bits with zeros up to a full byte.
   always_comb begin
      if (entry.flush) begin
         len_eff = (held == 3'd0) ? 6'd0 : 6'd8 - {3'd0, held};
      end else begin
         len_eff = entry.len;
      end
   end

   assign merged    = {work_ff[WORK_W-1 -: 7], {FIELD_W{1'b0}}}
                    | ({entry.field, 7'd0} >> held);
   assign src       = pop ? merged : work_ff;
   assign src_count = pop ? ({3'd0, held} + len_eff) : count_ff;
   assign emit      = (src_count >= 6'd8) && out_free;

   // Shift out one byte per cycle while the output is not stalled, and load the result register.
   always_comb begin
      work_in        = src;
      count_in       = src_count;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (emit) begin
         work_in                 = {src[WORK_W-9:0], 8'd0};
         count_in                = src_count - 6'd8;
         rsp_valid_in            = 1'b1;
         rsp_payload_in.out_byte = src[WORK_W-1 -: 8];
         rsp_payload_in.last     = (src_count < 6'd16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         work_ff      <= work_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

FILE: sv/bitstream_integer_writer.sv
// Top level of the MSB-first bitstream writer with byte varint integer codes.
// Each request transaction appends one field (raw bits, unsigned or signed byte varint,
// a 32-bit word low byte first, or a saturating unsigned or sign-magnitude field) to a
// continuous bit stream, or flushes the partial byte with zero padding; every completed
// byte leaves as one response transaction, first written bit in bit 7, with last set on
// the final byte caused by that request. The front end classifies a request in the cycle
// it is accepted and writes it to a two-entry queue; the packer takes one queued field
// per cycle while fewer than eight bits are held, sends out at most one byte per cycle,
// and holds a field that completes b bytes until all b are sent. Requests are taken
// every cycle while the queue has room. The first byte of a request passes through the
// queue entry and then the response register when nothing waits ahead of it.
`timescale 1ns / 1ps
`default_nettype none

module bitstream_integer_writer import biw_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire biw_req_type req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output biw_rsp_type      rsp_payload
);

   logic          queue_full;
   logic          push_valid;
   biw_entry_type push_entry;
   logic          pop;
   logic          pop_valid;
   biw_entry_type pop_entry;

   // Classification of incoming transactions.
   biw_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   // Decoupling queue.
   biw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // Bit packing and byte output.
   biw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (pop_valid),
      .entry       (pop_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: tb/bitstream_integer_writer_tb.sv
// Self-checking testbench for the bitstream integer writer.
`timescale 1ns / 1ps

module bitstream_integer_writer_tb;
   import biw_pkg::*;

   // Opcode that the writer ignores.
   localparam logic [2:0] OP_UNUSED = 3'd7;

   localparam int RANDOM_ITEMS = 400;
   localparam int TAIL_ITEMS   = 80;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_LEN     = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS  = 10;

   // One stimulus row; typed rows carry their expected bytes, first byte in the top bits.
   typedef struct packed {
      biw_req_type req;
      logic        typed;
      logic [2:0]  typed_n;
      logic [39:0] typed_bytes;
   } stim_item_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   biw_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   biw_rsp_type rsp_payload;

   stim_item_type stim_q[$];
   biw_rsp_type   byte_expect_q[$];
   logic [7:0]    item_bytes[$];

   // Copy of the packer state: bits 7..1 of the unfinished byte and how many are held.
   logic [6:0]  held_bits = '0;
   logic [2:0]  held_count = '0;

   int unsigned items_taken = 0;
   int unsigned fail_count = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_gap = 0;
   int unsigned hold_cnt = 0;
   logic        hold_done = 1'b0;

   bitstream_integer_writer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Appends one bit to the predicted stream, collecting each completed byte.
   function automatic void put_bit(input logic b);
      logic [7:0] cur;
      cur = {held_bits, 1'b0};
      if (b) cur[3'd7 - held_count] = 1'b1;
      if (held_count == 3'd7) begin
         item_bytes.push_back(cur);
         held_bits = '0;
         held_count = '0;
      end else begin
         held_bits = cur[7:1];
         held_count = held_count + 3'd1;
      end
   endfunction

   function automatic void put_bits(input logic [31:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) put_bit(v[i]);
   endfunction

   function automatic logic [31:0] saturate(input logic [31:0] v, input int n);
      logic [31:0] lim;
      lim = (32'd1 << n) - 32'd1;
      if (n < 32 && v > lim) return lim;
      return v;
   endfunction

   // Encodes one request into the predicted stream.
   function automatic void stream_field(input biw_req_type req);
      logic [31:0] v;
      logic [31:0] mag;
      logic [7:0]  chunk;
      logic        done;
      int          n;
      v = req.value;
      n = (req.bit_count > 6'd32) ? 32 : int'(req.bit_count);
      case (req.opcode)
         OP_RAW: put_bits(v, n);
         OP_UVARINT: begin
            while (v != 32'd0) begin
               put_bit(1'b1);
               put_bits({24'd0, v[7:0]}, 8);
               v = v >> 8;
            end
            put_bit(1'b0);
         end
         OP_SVARINT: begin
            if (v == 32'd0) begin
               put_bit(1'b0);
            end else begin
               done = 1'b0;
               for (int k = 0; k < 4 && !done; k++) begin
                  chunk = v[7:0];
                  put_bit(1'b1);
                  put_bits({24'd0, chunk}, 8);
                  v = {{8{v[31]}}, v[31:8]};
                  done = (v == 32'd0 && !chunk[7]) || (v == '1 && chunk[7]);
               end
               put_bit(1'b0);
            end
         end
         OP_WORD32: begin
            for (int k = 0; k < 4; k++) begin
               put_bits({24'd0, v[7:0]}, 8);
               v = v >> 8;
            end
         end
         OP_UNBITS: put_bits(saturate(v, n), n);
         OP_SNBITS: begin
            // The sign bit goes first; the magnitude of the most negative value is 2^31.
            if (n > 0) begin
               mag = v[31] ? (32'd0 - v) : v;
               put_bit(v[31]);
               put_bits(saturate(mag, n - 1), n - 1);
            end
         end
         OP_FLUSH: begin
            if (held_count != 3'd0) begin
               item_bytes.push_back({held_bits, 1'b0});
               held_bits = '0;
               held_count = '0;
            end
         end
         default: ;
      endcase
   endfunction

   // Turns one accepted request into expected response transactions.
   function automatic void predict_item(input stim_item_type item);
      biw_rsp_type rsp;
      item_bytes.delete();
      stream_field(item.req);
      if (item.typed) begin
         item_bytes.delete();
         for (int i = 0; i < int'(item.typed_n); i++)
            item_bytes.push_back(item.typed_bytes[39 - 8 * i -: 8]);
      end
      foreach (item_bytes[i]) begin
         rsp.out_byte = item_bytes[i];
         rsp.last = (i == item_bytes.size() - 1);
         byte_expect_q.push_back(rsp);
      end
   endfunction

   task automatic add_item(input logic [2:0] op, input logic [31:0] val, input logic [5:0] cnt,
                           input logic typed, input logic [2:0] n, input logic [39:0] bytes);
      stim_item_type item;
      item.req.opcode = op;
      item.req.value = val;
      item.req.bit_count = cnt;
      item.typed = typed;
      item.typed_n = n;
      item.typed_bytes = bytes;
      stim_q.push_back(item);
   endtask

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(5))
         0: v = $urandom;
         1: v = $urandom_range(255);
         2: v = 32'd0 - $urandom_range(300);
         3: v = $urandom >> $urandom_range(31);
         4: begin
            case ($urandom_range(4))
               0: v = 32'd0;
               1: v = 32'hFFFF_FFFF;
               2: v = 32'h8000_0000;
               3: v = 32'h7FFF_FFFF;
               default: v = 32'hFFFF_FF80;
            endcase
         end
         default: v = $urandom & ($urandom | $urandom);
      endcase
      return v;
   endfunction

   // Idling is allowed in bands of the run and never in its last part.
   function automatic bit idle_window(input int unsigned idx);
      return (idx + TAIL_ITEMS < stim_q.size()) && ((idx % 100) < 70);
   endfunction

   function automatic void report_mismatch(input string what, input biw_rsp_type exp_rsp,
                                           input biw_rsp_type act_rsp);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b", $realtime,
                  what, exp_rsp.out_byte, exp_rsp.last, act_rsp.out_byte, act_rsp.last);
   endfunction

   // Request driver: predicts each accepted transaction and presents the next one.
   always @(posedge clock) begin
      int unsigned nxt;
      nxt = items_taken;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_item(stim_q[items_taken]);
            nxt = items_taken + 1;
            items_taken <= nxt;
         end
         if (!(req_valid && req_stall)) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (nxt >= stim_q.size()) begin
               req_valid <= 1'b0;
            end else if (idle_window(nxt) && $urandom_range(5) == 0) begin
               req_valid <= 1'b0;
               req_gap <= $urandom_range(13);
            end else begin
               req_valid <= 1'b1;
               req_payload <= stim_q[nxt].req;
            end
         end
      end
   end

   // Long receiver hold-off, started once so that the writer fills up and stalls requests.
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && items_taken >= HOLD_AT) begin
            hold_cnt <= HOLD_LEN;
            hold_done <= 1'b1;
         end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
         end
      end
   end

   // Response stall in random bursts.
   always @(posedge clock) begin
      logic stall_nxt;
      stall_nxt = 1'b0;
      if (!reset) begin
         if (hold_cnt != 0) begin
            stall_nxt = 1'b1;
         end else if (rsp_gap != 0) begin
            stall_nxt = 1'b1;
            rsp_gap <= rsp_gap - 1;
         end else if (idle_window(items_taken) && $urandom_range(5) == 0) begin
            stall_nxt = 1'b1;
            rsp_gap <= $urandom_range(13);
         end
      end
      rsp_stall <= stall_nxt;
   end

   // Response checker: each accepted transaction against the oldest expectation.
   always @(posedge clock) begin
      biw_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (byte_expect_q.size() == 0) begin
            report_mismatch("unexpected transaction", '0, rsp_payload);
         end else begin
            exp_rsp = byte_expect_q.pop_front();
            if (rsp_payload.out_byte !== exp_rsp.out_byte || rsp_payload.last !== exp_rsp.last)
               report_mismatch("byte mismatch", exp_rsp, rsp_payload);
         end
      end
   end

   // Stimulus table, reset, and end of run.
   initial begin
      int unsigned counted;
      logic [2:0]  op;
      logic [5:0]  cnt;
      counted = 0;

      // Directed rows from the reset state; typed ones start byte aligned except the flushes that close a partial byte.
      add_item(OP_RAW,     32'h0000_00A5,  6'd8, 1'b1, 3'd1, 40'hA5_00_00_00_00);
      add_item(OP_WORD32,  32'h1234_5678,  6'd0, 1'b1, 3'd4, 40'h78_56_34_12_00);
      add_item(OP_FLUSH,   32'h0000_0000,  6'd0, 1'b1, 3'd0, 40'd0);
      add_item(OP_RAW,     32'hFFFF_FFFF, 6'd32, 1'b1, 3'd4, 40'hFF_FF_FF_FF_00);
      add_item(OP_RAW,     32'h1234_5678,  6'd0, 1'b1, 3'd0, 40'd0);
      add_item(OP_UNBITS,  32'd1000,       6'd4, 1'b1, 3'd0, 40'd0);
      add_item(OP_FLUSH,   32'hFFFF_FFFF,  6'd0, 1'b1, 3'd1, 40'hF0_00_00_00_00);
      add_item(OP_UVARINT, 32'h0000_0000,  6'd0, 1'b1, 3'd0, 40'd0);
      add_item(OP_FLUSH,   32'h0000_0000, 6'd63, 1'b1, 3'd1, 40'h00_00_00_00_00);
      add_item(OP_RAW,     32'hDEAD_BEEF, 6'd63, 1'b1, 3'd4, 40'hDE_AD_BE_EF_00);
      add_item(OP_SNBITS,  32'h8000_0000, 6'd32, 1'b1, 3'd4, 40'hFF_FF_FF_FF_00);
      add_item(OP_SNBITS,  32'hFFFF_FFFF,  6'd0, 1'b1, 3'd0, 40'd0);
      // Untyped rows, most of them unaligned, checked against the predictor.
      add_item(OP_UVARINT, 32'hFFFF_FFFF,  6'd0, 1'b0, 3'd0, 40'd0);
      add_item(OP_SVARINT, 32'h8000_0000,  6'd0, 1'b0, 3'd0, 40'd0);
      add_item(OP_SVARINT, 32'hFFFF_FFFF,  6'd0, 1'b0, 3'd0, 40'd0);
      add_item(OP_SVARINT, 32'h0000_0000,  6'd0, 1'b0, 3'd0, 40'd0);
      add_item(OP_SVARINT, 32'h0000_007F,  6'd0, 1'b0, 3'd0, 40'd0);
      add_item(OP_SVARINT, 32'h0000_0080,  6'd0, 1'b0, 3'd0, 40'd0);
      add_item(OP_SVARINT, 32'hFFFF_FF80,  6'd0, 1'b0, 3'd0, 40'd0);
      add_item(OP_SNBITS,  32'hFFFF_FFFB,  6'd1, 1'b0, 3'd0, 40'd0);
      add_item(OP_SNBITS,  32'h0000_0005,  6'd4, 1'b0, 3'd0, 40'd0);
      add_item(OP_UNBITS,  32'hFFFF_FFFF, 6'd40, 1'b0, 3'd0, 40'd0);
      add_item(OP_UNUSED,  32'h5555_AAAA, 6'd21, 1'b0, 3'd0, 40'd0);
      add_item(OP_SNBITS,  32'hFFFF_FFFD, 6'd63, 1'b0, 3'd0, 40'd0);
      add_item(OP_FLUSH,   32'h0000_0000,  6'd0, 1'b0, 3'd0, 40'd0);

      // Random part; ignored opcodes do not count toward the item budget.
      while (counted < RANDOM_ITEMS) begin
         op = ($urandom_range(24) == 0) ? OP_UNUSED : 3'($urandom_range(6));
         cnt = ($urandom_range(7) == 0) ? 6'($urandom_range(63, 33)) : 6'($urandom_range(32));
         add_item(op, pick_value(), cnt, 1'b0, 3'd0, 40'd0);
         if (op != OP_UNUSED) counted++;
      end
      add_item(OP_FLUSH, 32'h0000_0000, 6'd0, 1'b0, 3'd0, 40'd0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (!(items_taken == stim_q.size() && byte_expect_q.size() == 0)) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (byte_expect_q.size() != 0) begin
         fail_count += byte_expect_q.size();
         $display("%0d expected transactions never arrived", byte_expect_q.size());
      end
      if (fail_count == 0) begin
         $display("bitstream_integer_writer regression: pass");
      end else begin
         $display("bitstream_integer_writer regression: fail");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("bitstream_integer_writer regression: fail");
      $finish;
   end

endmodule
